// ===== rtl/core/pq_table_distance_accumulator_core_assert.svh =====
// Assertion macros for the core RTL (included by pqda_accum).
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef PQ_TABLE_DISTANCE_ACCUMULATOR_CORE_ASSERT_SVH
`define PQ_TABLE_DISTANCE_ACCUMULATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PQDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PQDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pqda_pkg.sv =====
`timescale 1ns / 1ps

package pqda_pkg;

    // Table geometry and value widths
    localparam int MAX_SUBQ     = 64;
    localparam int TABLE_STRIDE = 256;
    localparam int VALUE_WIDTH  = 32;
    localparam int SUBQ_W       = 6;
    localparam int ENTRY_W      = 8;
    localparam int TABLE_AW     = SUBQ_W + ENTRY_W;
    localparam int TABLE_DEPTH  = MAX_SUBQ * TABLE_STRIDE;
    localparam int DIST_WIDTH   = 40;
    localparam int NSQ_W        = 7;
    localparam int CB_W         = 4;
    localparam int CFG_IDX_W    = 2;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SUBQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS      = 2'd2;

    // Request kinds carried on s_tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CODE = 1'b1;

    localparam logic [DIST_WIDTH-1:0] DIST_MAX = {1'b0, {(DIST_WIDTH-1){1'b1}}};
    localparam logic [DIST_WIDTH-1:0] DIST_MIN = {1'b1, {(DIST_WIDTH-1){1'b0}}};

    // Control between the lookup front end and the accumulator
    typedef struct packed {
        logic valid;
        logic last;
    } step_t;

    typedef struct packed {
        logic                  ovf;
        logic [DIST_WIDTH-1:0] value;
    } sat_t;

    // Signed add of two 40-bit values, saturated to 40 bits
    function automatic sat_t sat_add(input logic [DIST_WIDTH-1:0] a,
                                     input logic [DIST_WIDTH-1:0] b);
        logic [DIST_WIDTH:0] sum;
        sat_t                r;
        sum = {a[DIST_WIDTH-1], a} + {b[DIST_WIDTH-1], b};
        r.ovf = sum[DIST_WIDTH] ^ sum[DIST_WIDTH-1];
        if (!r.ovf) begin
            r.value = sum[DIST_WIDTH-1:0];
        end else if (sum[DIST_WIDTH]) begin
            r.value = DIST_MIN;
        end else begin
            r.value = DIST_MAX;
        end
        return r;
    endfunction

    // Code mask for a code width, width clamped to 1..8
    function automatic logic [ENTRY_W-1:0] code_mask(input logic [CB_W-1:0] cb);
        logic [ENTRY_W-1:0] m;
        case (cb)
            4'd0, 4'd1: m = 8'h01;
            4'd2:       m = 8'h03;
            4'd3:       m = 8'h07;
            4'd4:       m = 8'h0F;
            4'd5:       m = 8'h1F;
            4'd6:       m = 8'h3F;
            4'd7:       m = 8'h7F;
            default:    m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/pqda_ram.sv =====
`timescale 1ns / 1ps

module pqda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; rdata holds when idle
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/pqda_accum.sv =====
`timescale 1ns / 1ps

module pqda_accum (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pqda_pkg::step_t                step,
    output logic                           step_ready,
    input  logic [pqda_pkg::VALUE_WIDTH-1:0] table_data,
    input  logic [31:0]                    bias,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pqda_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser
);
    import pqda_pkg::*;

    logic [DIST_WIDTH-1:0] acc_reg, acc_next;
    logic                  fin_valid_reg, fin_valid_next;
    logic [DIST_WIDTH-1:0] fin_acc_reg, fin_acc_next;
    logic                  fin_ovf_reg, fin_ovf_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DIST_WIDTH-1:0] out_dist_reg, out_dist_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic                  out_free;
    logic                  fin_free;
    logic                  step_adv;
    sat_t                  acc_sum;
    sat_t                  total;

    // Back-pressure through the final and output stages
    assign out_free   = !out_valid_reg || m_tready;
    assign fin_free   = !fin_valid_reg || out_free;
    assign step_ready = !step.last || fin_free;
    assign step_adv   = step.valid && step_ready;

    // Stage 1: add the table entry to the running sum
    assign acc_sum = sat_add(acc_reg,
                             {{(DIST_WIDTH-VALUE_WIDTH){table_data[VALUE_WIDTH-1]}},
                              table_data});
    // Stage 2: add the bias to the finished sum
    assign total = sat_add(fin_acc_reg,
                           {{(DIST_WIDTH-32){bias[31]}}, bias});

    always_comb begin
        acc_next       = acc_reg;
        fin_valid_next = fin_valid_reg;
        fin_acc_next   = fin_acc_reg;
        fin_ovf_next   = fin_ovf_reg;
        out_valid_next = out_valid_reg;
        out_dist_next  = out_dist_reg;
        out_ovf_next   = out_ovf_reg;

        // Output register drains
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        // Final stage moves into the output register
        if (fin_valid_reg && out_free) begin
            out_valid_next = 1'b1;
            out_dist_next  = total.value;
            out_ovf_next   = total.ovf | fin_ovf_reg;
            fin_valid_next = 1'b0;
        end
        // Accumulate; a last step hands the sum on and clears
        if (step_adv) begin
            if (step.last) begin
                fin_valid_next = 1'b1;
                fin_acc_next   = acc_sum.value;
                fin_ovf_next   = acc_sum.ovf;
                acc_next       = '0;
            end else begin
                acc_next = acc_sum.value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
        fin_acc_reg  <= fin_acc_next;
        fin_ovf_reg  <= fin_ovf_next;
        out_dist_reg <= out_dist_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_dist_reg;
    assign m_tuser  = out_ovf_reg;

`include "pq_table_distance_accumulator_core_assert.svh"

    `PQDA_ASSERT_NEXT(a_stall_holds_sum, step.valid && !step_ready, $stable(acc_reg), "sum changed while step stalled")
    `PQDA_ASSERT_NEXT(a_last_clears_sum, step_adv && step.last, acc_reg == '0, "sum not cleared after vector end")
    `PQDA_ASSERT_NEXT(a_final_not_lost, fin_valid_reg && !out_free, fin_valid_reg, "finished sum dropped")
    `PQDA_ASSERT_NOW(a_no_last_into_full, step.valid && step.last && !fin_free, !step_adv, "vector end overran final stage")

endmodule

// ===== rtl/core/pq_table_distance_accumulator_core.sv =====
`timescale 1ns / 1ps
// Channel | Direction | tdata (low bit up)                                | tuser
// s_      | in        | table_subq, table_entry, table_value, code_byte   | cmd
// m_      | out       | distance                                          | overflow
// cfg_    | in        | cfg_index selects register, cfg_data is the value | -
//
// One request per cycle while s_tready is high: a load writes the table RAM at its
// accept edge; a code issues one table RAM read and its read entry is accumulated.
// A distance reaches m_tvalid through the RAM read at accept, the accumulate into the
// final stage and the bias add, which has its own stage, into the output register.
// Synchronous active-low reset clears sums and position; the table is not cleared.
// A stalled m_ side holds the output register, then the final stage, then s_tready.

module pq_table_distance_accumulator_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // table_subq[5:0], table_entry[13:6], table_value[45:14], code_byte[53:46]
    input  logic [pqda_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // distance[39:0]
    output logic [pqda_pkg::M_TDATA_W-1:0]   m_tdata,
    // overflow
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pqda_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);
    import pqda_pkg::*;

    logic [NSQ_W-1:0]       num_subq_reg;
    logic [CB_W-1:0]        code_bits_reg;
    logic [31:0]            bias_reg;
    logic [SUBQ_W-1:0]      pos_reg, pos_next;
    step_t                  step_reg, step_next;

    logic                   step_ready;
    logic                   s_accept;
    logic                   code_req;
    logic                   load_req;
    logic [SUBQ_W-1:0]      in_subq;
    logic [ENTRY_W-1:0]     in_entry;
    logic [VALUE_WIDTH-1:0] in_value;
    logic [ENTRY_W-1:0]     in_code;
    logic [NSQ_W-1:0]       nsq_eff;
    logic [NSQ_W-1:0]       pos_inc;
    logic                   is_last;
    logic [VALUE_WIDTH-1:0] table_data;

    // Unpack the request
    assign in_subq  = s_tdata[5:0];
    assign in_entry = s_tdata[13:6];
    assign in_value = s_tdata[45:14];
    assign in_code  = s_tdata[53:46];

    assign cfg_ready = 1'b1;
    assign s_tready  = !step_reg.valid || step_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign code_req  = s_accept && (s_tuser == CMD_CODE);
    assign load_req  = s_accept && (s_tuser == CMD_LOAD);

    // Vector length clamped to 1..64
    always_comb begin
        if (num_subq_reg == '0) begin
            nsq_eff = NSQ_W'(1);
        end else if (num_subq_reg > NSQ_W'(MAX_SUBQ)) begin
            nsq_eff = NSQ_W'(MAX_SUBQ);
        end else begin
            nsq_eff = num_subq_reg;
        end
    end

    // Position tracking at accept time
    assign pos_inc = {1'b0, pos_reg} + NSQ_W'(1);
    assign is_last = pos_inc >= nsq_eff;

    always_comb begin
        pos_next  = pos_reg;
        step_next = step_reg;
        if (step_reg.valid && step_ready) begin
            step_next.valid = 1'b0;
        end
        if (code_req) begin
            step_next.valid = 1'b1;
            step_next.last  = is_last;
            pos_next        = is_last ? '0 : pos_inc[SUBQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_subq_reg   <= NSQ_W'(8);
            code_bits_reg  <= CB_W'(8);
            bias_reg       <= '0;
            pos_reg        <= '0;
            step_reg.valid <= 1'b0;
            step_reg.last  <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            step_reg <= step_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NUM_SUBQ:  num_subq_reg  <= cfg_data[NSQ_W-1:0];
                    CFG_CODE_BITS: code_bits_reg <= cfg_data[CB_W-1:0];
                    CFG_BIAS:      bias_reg      <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // Lookup table: row per subquantizer, column per centroid
    pqda_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (load_req),
        .waddr ({in_subq, in_entry}),
        .wdata (in_value),
        .re    (code_req),
        .raddr ({pos_reg, in_code & code_mask(code_bits_reg)}),
        .rdata (table_data)
    );

    pqda_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step_reg),
        .step_ready (step_ready),
        .table_data (table_data),
        .bias       (bias_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pqda_pkg::*;

    localparam int     RAND_ITEMS  = 1630;
    localparam int     DRAIN_CYC   = 8;
    localparam int     HOLD_CYC    = 300;
    localparam int     STALL_LIMIT = 4000;
    localparam int     HOLD_PHASE  = 3;
    localparam longint DIST_HI     = 64'sd549755813887;
    localparam longint DIST_LO     = -64'sd549755813888;

    typedef enum logic [1:0] {ROW_LOAD, ROW_CODE, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [DIST_WIDTH-1:0] dist_val;
        logic                  ovf;
    } dist_res_t;

    // One directed step; known_dist is used only where known is set
    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [SUBQ_W-1:0]     subq;
        logic [ENTRY_W-1:0]    entry;
        logic [31:0]           word;
        logic [7:0]            code;
        bit                    known;
        logic [DIST_WIDTH-1:0] known_dist;
    } plan_row_t;

    localparam int N_ROWS = 25;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = CMD_LOAD;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_NUM_SUBQ;
    logic [31:0]            cfg_data  = '0;

    // Shadow of the block: table, running sum, position, registers
    logic signed [VALUE_WIDTH-1:0] lut_model [TABLE_DEPTH];
    bit                            lut_loaded [TABLE_DEPTH];
    longint                        acc_model = 0;
    logic [SUBQ_W-1:0]             pos_model = '0;
    logic [NSQ_W-1:0]              nsq_reg   = 7'd8;
    logic [CB_W-1:0]               cb_reg    = 4'd8;
    logic signed [31:0]            bias_reg  = '0;

    dist_res_t distance_q [$];
    int        mismatches   = 0;
    int        reqs_sent    = 0;
    int        quiet_cycles = 0;
    bit        send_lazy    = 1'b1;
    bit        recv_lazy    = 1'b1;
    bit        hold_req     = 1'b0;

    plan_row_t plan [N_ROWS] = '{
        '{ROW_CFG,  CFG_NUM_SUBQ,  6'd0,  8'h00, 32'd1,        8'h00, 1'b0, 40'h0},
        '{ROW_LOAD, CFG_NUM_SUBQ,  6'd0,  8'h00, 32'h7FFF_FFFF, 8'h00, 1'b0, 40'h0},
        '{ROW_CODE, CFG_NUM_SUBQ,  6'd0,  8'h00, 32'h0,        8'h00, 1'b1, 40'h00_7FFF_FFFF},
        '{ROW_LOAD, CFG_NUM_SUBQ,  6'd0,  8'hFF, 32'h8000_0000, 8'h00, 1'b0, 40'h0},
        '{ROW_CODE, CFG_NUM_SUBQ,  6'd0,  8'h00, 32'h0,        8'hFF, 1'b1, 40'hFF_8000_0000},
        // code width zero behaves as one bit
        '{ROW_CFG,  CFG_CODE_BITS, 6'd0,  8'h00, 32'd0,        8'h00, 1'b0, 40'h0},
        '{ROW_CODE, CFG_NUM_SUBQ,  6'd0,  8'h00, 32'h0,        8'hFE, 1'b1, 40'h00_7FFF_FFFF},
        '{ROW_LOAD, CFG_NUM_SUBQ,  6'd0,  8'h01, 32'h0001_0000, 8'h00, 1'b0, 40'h0},
        '{ROW_CODE, CFG_NUM_SUBQ,  6'd0,  8'h00, 32'h0,        8'hFF, 1'b1, 40'h00_0001_0000},
        // code width above eight acts as eight; length zero acts as one
        '{ROW_CFG,  CFG_CODE_BITS, 6'd0,  8'h00, 32'hFFFF_FFFF, 8'h00, 1'b0, 40'h0},
        '{ROW_CFG,  CFG_BIAS,      6'd0,  8'h00, 32'h7FFF_FFFF, 8'h00, 1'b0, 40'h0},
        '{ROW_CFG,  CFG_NUM_SUBQ,  6'd0,  8'h00, 32'hFFFF_FF80, 8'h00, 1'b0, 40'h0},
        '{ROW_CODE, CFG_NUM_SUBQ,  6'd0,  8'h00, 32'h0,        8'hFF, 1'b1, 40'hFF_FFFF_FFFF},
        '{ROW_CFG,  CFG_BIAS,      6'd0,  8'h00, 32'h8000_0000, 8'h00, 1'b0, 40'h0},
        '{ROW_CFG,  CFG_NUM_SUBQ,  6'd0,  8'h00, 32'd2,        8'h00, 1'b0, 40'h0},
        '{ROW_LOAD, CFG_NUM_SUBQ,  6'd1,  8'h00, 32'h7FFF_FFFF, 8'h00, 1'b0, 40'h0},
        '{ROW_CODE, CFG_NUM_SUBQ,  6'd0,  8'h00, 32'h0,        8'h00, 1'b0, 40'h0},
        '{ROW_CODE, CFG_NUM_SUBQ,  6'd0,  8'h00, 32'h0,        8'h00, 1'b0, 40'h0},
        '{ROW_CFG,  CFG_NUM_SUBQ,  6'd0,  8'h00, 32'd4,        8'h00, 1'b0, 40'h0},
        '{ROW_LOAD, CFG_NUM_SUBQ,  6'd2,  8'h00, 32'h0000_0100, 8'h00, 1'b0, 40'h0},
        '{ROW_CODE, CFG_NUM_SUBQ,  6'd0,  8'h00, 32'h0,        8'h00, 1'b0, 40'h0},
        '{ROW_CODE, CFG_NUM_SUBQ,  6'd0,  8'h00, 32'h0,        8'h00, 1'b0, 40'h0},
        // shorten the vector while two codes are already summed
        '{ROW_CFG,  CFG_NUM_SUBQ,  6'd0,  8'h00, 32'd2,        8'h00, 1'b0, 40'h0},
        '{ROW_CODE, CFG_NUM_SUBQ,  6'd0,  8'h00, 32'h0,        8'h00, 1'b0, 40'h0},
        '{ROW_LOAD, CFG_NUM_SUBQ,  6'd63, 8'hFF, 32'h5555_AAAA, 8'h00, 1'b0, 40'h0}
    };

    pq_table_distance_accumulator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // tdata: subq[5:0], entry[13:6], value[45:14], code[53:46], zero pad above
    function automatic logic [S_TDATA_W-1:0] pack_req(input logic [SUBQ_W-1:0] subq,
                                                     input logic [ENTRY_W-1:0] entry,
                                                     input logic [31:0] value,
                                                     input logic [7:0] code);
        return {2'b00, code, value, entry, subq};
    endfunction

    // Mask for the current code width, width limited to 1..8
    function automatic logic [7:0] code_mask_now();
        int cb;
        cb = (cb_reg == 0) ? 1 : ((cb_reg > 8) ? 8 : int'(cb_reg));
        return 8'hFF >> (8 - cb);
    endfunction

    function automatic longint clamp_dist(input longint v, inout bit ovf);
        if (v > DIST_HI) begin
            ovf = 1'b1;
            return DIST_HI;
        end
        if (v < DIST_LO) begin
            ovf = 1'b1;
            return DIST_LO;
        end
        return v;
    endfunction

    // Advance the shadow by one accepted request; returns 1 when a distance is due
    function automatic bit predict_distance(input logic cmd,
                                            input logic [S_TDATA_W-1:0] data,
                                            output dist_res_t res);
        logic [TABLE_AW-1:0] idx;
        int                  nsq_eff;
        bit                  ovf;
        longint              total;
        res = '0;
        ovf = 1'b0;
        if (cmd == CMD_LOAD) begin
            idx = {data[5:0], data[13:6]};
            lut_model[idx]  = data[45:14];
            lut_loaded[idx] = 1'b1;
            return 1'b0;
        end
        idx = {pos_model, data[53:46] & code_mask_now()};
        acc_model = clamp_dist(acc_model + longint'(lut_model[idx]), ovf);
        pos_model = pos_model + 1'b1;
        nsq_eff = (nsq_reg == 0) ? 1 : ((nsq_reg > MAX_SUBQ) ? MAX_SUBQ : int'(nsq_reg));
        if (pos_model != 0 && pos_model < nsq_eff) begin
            return 1'b0;
        end
        total        = clamp_dist(acc_model + longint'(bias_reg), ovf);
        res.dist_val = total[DIST_WIDTH-1:0];
        res.ovf      = ovf;
        acc_model    = 0;
        pos_model    = '0;
        return 1'b1;
    endfunction

    // Table values lean on the extremes
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [DIST_WIDTH-1:0] got,
                                   input logic [DIST_WIDTH-1:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offer one request after a random gap and update the shadow on accept
    task automatic send_req(input logic cmd, input logic [S_TDATA_W-1:0] data,
                            input bit known, input logic [DIST_WIDTH-1:0] known_dist);
        int        gap;
        dist_res_t res;
        gap = send_lazy ? $urandom_range(0, 14) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        reqs_sent++;
        if (predict_distance(cmd, data, res)) begin
            if (known) begin
                res.dist_val = known_dist;
                res.ovf      = 1'b0;
            end
            distance_q.push_back(res);
        end
    endtask

    // Stop offering, wait for all distances, then let the pipeline drain
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (distance_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] word);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_NUM_SUBQ:  nsq_reg  = word[NSQ_W-1:0];
            CFG_CODE_BITS: cb_reg   = word[CB_W-1:0];
            CFG_BIAS:      bias_reg = word;
            default:       ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, one long hold on request, field checks
    initial begin
        int        gap;
        dist_res_t want;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                recv_lazy = ~recv_lazy;
            end
            gap = recv_lazy ? $urandom_range(0, 14) : 0;
            if (hold_req) begin
                gap      = HOLD_CYC;
                hold_req = 1'b0;
            end
            @(negedge aclk);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            if (distance_q.size() == 0) begin
                report_mismatch("distance with none pending", m_tdata, '0);
            end else begin
                want = distance_q.pop_front();
                if (m_tdata !== want.dist_val) begin
                    report_mismatch("distance", m_tdata, want.dist_val);
                end
                if (m_tuser !== want.ovf) begin
                    report_mismatch("overflow", 40'(m_tuser), 40'(want.ovf));
                end
            end
        end
    end

    // Watchdog on cycles without any handshake on s_, m_ or cfg_
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int                phase;
        int                len;
        int                stop_at;
        bit                hold_phase;
        logic [7:0]        code_v;
        logic [7:0]        hit;
        logic [31:0]       word;
        logic [TABLE_AW-1:0] idx;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows
        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_CFG: begin
                    settle();
                    write_cfg(plan[i].reg_idx, plan[i].word);
                end
                ROW_LOAD: begin
                    send_req(CMD_LOAD, pack_req(plan[i].subq, plan[i].entry, plan[i].word,
                             8'h00), 1'b0, '0);
                end
                default: begin
                    send_req(CMD_CODE, pack_req('0, '0, '0, plan[i].code),
                             plan[i].known, plan[i].known_dist);
                end
            endcase
        end

        // random phases, each of which may change the register settings
        phase   = 0;
        stop_at = reqs_sent + RAND_ITEMS;
        while (reqs_sent < stop_at) begin
            settle();
            hold_phase = (phase == HOLD_PHASE);
            if (hold_phase) begin
                write_cfg(CFG_NUM_SUBQ, 32'd1);
            end else begin
                if ($urandom_range(0, 2) != 0) begin
                    case ($urandom_range(0, 9))
                        0:       word = 32'd64;
                        1:       word = 32'd0;
                        2:       word = $urandom_range(65, 127);
                        3:       word = $urandom_range(9, 63);
                        default: word = $urandom_range(1, 8);
                    endcase
                    write_cfg(CFG_NUM_SUBQ, ($urandom() & 32'hFFFF_FF80) | word);
                end
                if ($urandom_range(0, 2) != 0) begin
                    case ($urandom_range(0, 7))
                        0:       word = 32'd0;
                        1:       word = $urandom_range(9, 15);
                        default: word = $urandom_range(1, 8);
                    endcase
                    write_cfg(CFG_CODE_BITS, ($urandom() & 32'hFFFF_FFF0) | word);
                end
                if ($urandom_range(0, 2) != 0) begin
                    case ($urandom_range(0, 5))
                        0:       word = 32'h7FFF_FFFF;
                        1:       word = 32'h8000_0000;
                        2:       word = 32'h0;
                        default: word = $urandom();
                    endcase
                    write_cfg(CFG_BIAS, word);
                end
            end
            len       = hold_phase ? 80 : $urandom_range(20, 120);
            send_lazy = hold_phase ? 1'b0 : ($urandom_range(0, 3) != 0);
            hold_req  = hold_phase;
            repeat (len) begin
                if ($urandom_range(0, 9) == 0) begin
                    // stray table write anywhere
                    send_req(CMD_LOAD, pack_req(SUBQ_W'($urandom()), ENTRY_W'($urandom()),
                             pick_value(), 8'($urandom())), 1'b0, '0);
                end else begin
                    // code for the current position; load its entry first if still empty
                    code_v = 8'($urandom_range(0, 255));
                    hit    = code_v & code_mask_now();
                    idx    = {pos_model, hit};
                    if (!lut_loaded[idx]) begin
                        send_req(CMD_LOAD, pack_req(pos_model, hit, pick_value(),
                                 8'($urandom())), 1'b0, '0);
                    end
                    send_req(CMD_CODE, pack_req(SUBQ_W'($urandom()), ENTRY_W'($urandom()),
                             $urandom(), code_v), 1'b0, '0);
                end
            end
            phase++;
        end

        settle();
        if (mismatches == 0 && distance_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
